// File: rtl/sph_pkg.sv
package sph_pkg;

  localparam int MaxPoints = 64;
  localparam int CoordBits = 16;
  localparam int IdxBits = $clog2(MaxPoints);
  localparam int CntBits = IdxBits + 1;
  localparam int StkBits = $clog2(2 * MaxPoints);
  localparam int StkCntBits = StkBits + 1;
  localparam int BandBits = 15;
  localparam logic [BandBits-1:0] BandReset = 15'd256;
  localparam int QDepth = 2;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t z;
  } point_t;

  // front-to-back command: a kept point and/or the end of the set
  typedef struct packed {
    logic   keep;
    logic   fin;
    point_t pt;
  } cmd_t;

  typedef struct packed {
    coord_t x;
    coord_t z;
    logic   last;
    logic   empty;
    logic   dropped;
  } res_t;

endpackage

// File: rtl/sph_front.sv
module sph_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sph_pkg::coord_t               pos_x,
  input  sph_pkg::coord_t               pos_h,
  input  sph_pkg::coord_t               pos_z,
  input  logic                          fin,
  input  logic                          cfg_valid,
  input  logic [sph_pkg::BandBits-1:0]  cfg_data,
  output logic                          q_valid,
  input  logic                          q_ready,
  output sph_pkg::cmd_t                 q_cmd
);

  logic [sph_pkg::BandBits-1:0] band_r;
  sph_pkg::cmd_t                q_r [sph_pkg::QDepth];
  logic [1:0]                   cnt_r;
  logic                         wr_r, rd_r;
  logic signed [sph_pkg::CoordBits:0] h_e, b_e;
  logic                         keep;
  logic                         push, pop;

  always_comb begin
    h_e  = {pos_h[sph_pkg::CoordBits-1], pos_h};
    b_e  = {{(sph_pkg::CoordBits + 1 - sph_pkg::BandBits){1'b0}}, band_r};
    keep = (h_e < b_e) && (h_e > -b_e);
  end

  assign in_ready = (cnt_r != 2'(sph_pkg::QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= sph_pkg::BandReset;
      cnt_r  <= '0;
      wr_r   <= 1'b0;
      rd_r   <= 1'b0;
    end else begin
      if (cfg_valid) band_r <= cfg_data;
      if (push) begin
        q_r[wr_r] <= '{keep: keep, fin: fin, pt: '{x: pos_x, z: pos_z}};
        wr_r      <= ~wr_r;
      end
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/sph_back.sv
module sph_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  sph_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output sph_pkg::res_t out_res
);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_HULL_START, S_RD_PT, S_RD_STK, S_CROSS,
    S_DECIDE, S_EMIT_RD, S_EMIT, S_EMIT_EMPTY
  } state_t;

  typedef logic signed [sph_pkg::CoordBits:0]       diff_t;
  typedef logic signed [2*sph_pkg::CoordBits+1:0]   prod_t;

  state_t state_r;
  sph_pkg::point_t store [sph_pkg::MaxPoints];
  sph_pkg::point_t stack [2 * sph_pkg::MaxPoints];

  logic [sph_pkg::CntBits-1:0]    n_r, i_r;
  logic [sph_pkg::StkCntBits-1:0] m_r, t_r, k_r;
  logic                           ovf_r, upper_r, fin_r;
  sph_pkg::point_t                new_r, rd_r, p_r, a_r, o_r, s_rd_r;
  prod_t                          pp_r, pq_r;
  sph_pkg::res_t                  res_r;
  logic                           ov_r;

  diff_t ax, az, bx, bz;
  logic  new_lt;
  logic  not_left;
  logic  emit_go;

  always_comb begin
    new_lt = (new_r.x < rd_r.x) || ((new_r.x == rd_r.x) && (new_r.z < rd_r.z));
    ax = diff_t'(a_r.x) - diff_t'(o_r.x);
    az = diff_t'(a_r.z) - diff_t'(o_r.z);
    bx = diff_t'(p_r.x) - diff_t'(o_r.x);
    bz = diff_t'(p_r.z) - diff_t'(o_r.z);
    not_left = (pp_r <= pq_r);
  end

  assign q_ready   = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_res   = res_r;
  assign emit_go   = ((state_r == S_EMIT) || (state_r == S_EMIT_EMPTY)) &&
                     (!ov_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r     <= '0;
      k_r     <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (emit_go) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (q_valid) begin
          fin_r <= q_cmd.fin;
          new_r <= q_cmd.pt;
          i_r   <= n_r;
          if (q_cmd.keep && n_r == sph_pkg::CntBits'(sph_pkg::MaxPoints)) ovf_r <= 1'b1;
          if (q_cmd.keep && n_r != sph_pkg::CntBits'(sph_pkg::MaxPoints)) begin
            state_r <= S_INS_RD;
          end else if (q_cmd.fin) begin
            state_r <= S_HULL_START;
          end
        end
        S_INS_RD: begin
          if (i_r == '0) begin
            store[0] <= new_r;
            n_r      <= n_r + 1'b1;
            state_r  <= fin_r ? S_HULL_START : S_IDLE;
          end else begin
            rd_r    <= store[i_r[sph_pkg::IdxBits-1:0] - 1'b1];
            state_r <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (new_lt) begin
            store[i_r[sph_pkg::IdxBits-1:0]] <= rd_r;
            i_r     <= i_r - 1'b1;
            state_r <= S_INS_RD;
          end else begin
            store[i_r[sph_pkg::IdxBits-1:0]] <= new_r;
            n_r     <= n_r + 1'b1;
            state_r <= fin_r ? S_HULL_START : S_IDLE;
          end
        end
        S_HULL_START: begin
          m_r     <= '0;
          i_r     <= '0;
          upper_r <= 1'b0;
          t_r     <= sph_pkg::StkCntBits'(2);
          if (n_r == '0) state_r <= S_EMIT_EMPTY;
          else state_r <= S_RD_PT;
        end
        // fetch point i (lower: ascending, upper: i already set)
        S_RD_PT: begin
          p_r     <= store[i_r[sph_pkg::IdxBits-1:0]];
          state_r <= S_RD_STK;
        end
        S_RD_STK: begin
          if (m_r >= t_r) begin
            a_r <= stack[m_r[sph_pkg::StkBits-1:0] - 1'b1];
            o_r <= stack[m_r[sph_pkg::StkBits-1:0] - 2'd2];
            state_r <= S_CROSS;
          end else begin
            // chain too short to test: push, then move on to the next point
            stack[m_r[sph_pkg::StkBits-1:0]] <= p_r;
            m_r     <= m_r + 1'b1;
            k_r     <= sph_pkg::StkCntBits'(1);
            state_r <= S_DECIDE;
          end
        end
        S_CROSS: begin
          pp_r    <= prod_t'(ax) * prod_t'(bz);
          pq_r    <= prod_t'(az) * prod_t'(bx);
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (m_r >= t_r && state_r == S_DECIDE && not_left && k_r == '0) begin
            m_r     <= m_r - 1'b1;
            state_r <= S_RD_STK;
          end else if (m_r >= t_r && k_r == '0) begin
            stack[m_r[sph_pkg::StkBits-1:0]] <= p_r;
            m_r     <= m_r + 1'b1;
            k_r     <= sph_pkg::StkCntBits'(1);
          end else begin
            k_r <= '0;
            if (!upper_r) begin
              if (i_r + 1'b1 == n_r) begin
                upper_r <= 1'b1;
                t_r     <= m_r + 1'b1;
                if (n_r == sph_pkg::CntBits'(1)) begin
                  state_r <= S_EMIT_RD;
                end else begin
                  i_r     <= i_r - 1'b1;
                  state_r <= S_RD_PT;
                end
              end else begin
                i_r     <= i_r + 1'b1;
                state_r <= S_RD_PT;
              end
            end else if (i_r == '0) begin
              m_r     <= m_r - 1'b1;
              state_r <= S_EMIT_RD;
            end else begin
              i_r     <= i_r - 1'b1;
              state_r <= S_RD_PT;
            end
          end
        end
        S_EMIT_RD: begin
          s_rd_r  <= stack[k_r[sph_pkg::StkBits-1:0]];
          state_r <= S_EMIT;
        end
        S_EMIT: if (emit_go) begin
          res_r   <= '{x: s_rd_r.x, z: s_rd_r.z, last: (k_r + 1'b1 == m_r),
                       empty: 1'b0, dropped: ovf_r};
          if (k_r + 1'b1 == m_r) begin
            k_r <= '0; n_r <= '0; ovf_r <= 1'b0; state_r <= S_IDLE;
          end else begin
            k_r <= k_r + 1'b1; state_r <= S_EMIT_RD;
          end
        end
        S_EMIT_EMPTY: if (emit_go) begin
          res_r   <= '{x: '0, z: '0, last: 1'b1, empty: 1'b1, dropped: ovf_r};
          ovf_r   <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/surface_points_convex_hull.sv
// channel | dir | fields (low bit first)
// in      | in  | tdata: pos_x, pos_height, pos_z; tlast: final_vertex
// out     | out | tdata: hull_x, hull_z; tuser: hull_empty, points_dropped; tlast: last_point
// cfg     | in  | data: surface_band
// A kept point is inserted into the sorted store by shifting larger points up one slot;
// the hull pass builds the lower and upper chains on a stack, popping non-left turns, then emits them.
// The back end takes no new command until it is idle again. Synchronous active-low reset
// clears counts and flags; the front queue holds two items, so input is still taken while the back end is busy.
module surface_points_convex_hull (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pos_x, pos_height, pos_z
  input  logic        in_tlast,   // final_vertex
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data,   // surface_band
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // hull_x, hull_z
  output logic [1:0]  out_tuser,  // hull_empty, points_dropped
  output logic        out_tlast   // last_point
);

  logic          q_valid, q_ready;
  sph_pkg::cmd_t q_cmd;
  sph_pkg::res_t res;

  assign cfg_ready = 1'b1;

  sph_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .pos_x(in_tdata[15:0]), .pos_h(in_tdata[31:16]), .pos_z(in_tdata[47:32]),
    .fin(in_tlast), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  sph_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {res.z, res.x};
  assign out_tuser = {res.dropped, res.empty};
  assign out_tlast = res.last;

endmodule
